// File: rtl/core/gfli_pkg.sv
// shared types and constants for the grid field linear interpolator
`timescale 1ns / 1ps

package gfli_pkg;

    localparam int NUM_COMP    = 6;   // e_x, e_y, e_z, b_x, b_y, b_z
    localparam int COMP_W      = 32;  // Q16.16 component on the ports
    localparam int POS_W       = 32;  // Q16.16 position
    localparam int INDEX_W     = 10;
    localparam int WEIGHT_W    = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int LATENCY     = 7;   // accept edge to the edge that takes the result

    localparam logic signed [POS_W-1:0] MIN_POSITION_RESET    = '0;
    localparam logic [CFG_DATA_W-1:0]   INVERSE_SPACING_RESET = 32'd65536;
    localparam logic [INDEX_W-1:0]      LAST_INDEX_RESET      = 10'd1;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MIN_POSITION    = 2'd0,
        CFG_INVERSE_SPACING = 2'd1,
        CFG_LAST_INDEX      = 2'd2
    } t_cfg_index;

    typedef struct packed {
        t_kind                     kind;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [COMP_W-1:0]  load_e_x;
        logic signed [COMP_W-1:0]  load_e_y;
        logic signed [COMP_W-1:0]  load_e_z;
        logic signed [COMP_W-1:0]  load_b_x;
        logic signed [COMP_W-1:0]  load_b_y;
        logic signed [COMP_W-1:0]  load_b_z;
        logic signed [POS_W-1:0]   position;
    } t_in_item;

    typedef struct packed {
        logic signed [COMP_W-1:0] field_e_x;
        logic signed [COMP_W-1:0] field_e_y;
        logic signed [COMP_W-1:0] field_e_z;
        logic signed [COMP_W-1:0] field_b_x;
        logic signed [COMP_W-1:0] field_b_y;
        logic signed [COMP_W-1:0] field_b_z;
    } t_out_item;

endpackage

// File: rtl/core/grid_field_linear_interp.sv
// top level: field table with linear interpolation on a uniform grid
`timescale 1ns / 1ps

// usage
// - item channel: an item is taken at each rising edge with start high and busy low;
//   busy is always low, so a new item can follow in every cycle
// - a load item (kind load) writes one grid entry of three electric and three
//   magnetic components; it gives no result
// - a query item (kind query) gives a position; its result appears on o_result with
//   o_strobe high for one cycle
// - one item per cycle sustained, fixed latency; seven register stages: offset,
//   32x32 scale multiply, index select, dual-port table read, neighbor difference,
//   weight multiply, output add
// - loads and queries meet the table in the same stage, so a query sees every load
//   taken before it and none taken after it
// - configuration channel: index and data, taken with i_cfg_valid while o_cfg_ready
//   is high (always); write it only while no query is in flight
// - synchronous reset clears the pipeline valid bits and the configuration
//   registers; the table is not cleared and is undefined until loaded
// - results cannot be held off: the receiver takes each one in its strobe cycle
module grid_field_linear_interp #(
    parameter int GRID_DEPTH      = 1024,
    parameter int COMPONENT_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  gfli_pkg::t_in_item                  i_item,
    output logic                                o_strobe,
    output gfli_pkg::t_out_item                 o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gfli_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [gfli_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import gfli_pkg::*;

    // stored component width, capped at the port width
    localparam int EW      = (COMPONENT_WIDTH > COMP_W) ? COMP_W : COMPONENT_WIDTH;
    localparam int AW      = $clog2(GRID_DEPTH);
    localparam int ENTRY_W = NUM_COMP * EW;
    localparam logic [31:0] DEPTH_32    = 32'(GRID_DEPTH);
    localparam logic [31:0] LAST_MAX_32 = 32'(GRID_DEPTH - 1);

    // configuration registers
    logic signed [POS_W-1:0]    r_cfg_min;
    logic [CFG_DATA_W-1:0]      r_cfg_inv;
    logic [INDEX_W-1:0]         r_cfg_last;

    logic accept;

    // stage 1: offset from grid start
    logic                       r_s1_valid;
    t_kind                      r_s1_kind;
    logic [INDEX_W-1:0]         r_s1_index;
    logic [EW-1:0]              r_s1_load [NUM_COMP];
    logic signed [POS_W:0]      r_s1_diff;
    logic signed [POS_W:0]      n_s1_diff;
    logic [EW-1:0]              n_s1_load [NUM_COMP];

    // stage 2: scaled grid coordinate
    logic                       r_s2_valid;
    t_kind                      r_s2_kind;
    logic [INDEX_W-1:0]         r_s2_index;
    logic [EW-1:0]              r_s2_load [NUM_COMP];
    logic [31:0]                r_s2_ip;
    logic [WEIGHT_W-1:0]        r_s2_w;
    logic [63:0]                n_s2_grid;
    logic                       n_s2_below;

    // stage 3: table addresses
    logic                       r_s3_valid;
    t_kind                      r_s3_kind;
    logic [AW-1:0]              r_s3_addr_a;
    logic [AW-1:0]              r_s3_addr_b;
    logic [WEIGHT_W-1:0]        r_s3_w;
    logic                       r_s3_wr_en;
    logic [ENTRY_W-1:0]         r_s3_wdata;
    logic [31:0]                n_s3_last;
    logic                       n_s3_endpoint;
    logic [AW-1:0]              n_s3_left;
    logic [AW-1:0]              n_s3_addr_a;
    logic [AW-1:0]              n_s3_addr_b;
    logic [WEIGHT_W-1:0]        n_s3_w;
    logic [31:0]                n_s3_index;
    logic [ENTRY_W-1:0]         n_s3_wdata;

    // stage 4: table read
    logic [ENTRY_W-1:0]         r_grid_mem [GRID_DEPTH];
    logic                       r_s4_valid;
    logic [ENTRY_W-1:0]         r_rd_a;
    logic [ENTRY_W-1:0]         r_rd_b;
    logic [WEIGHT_W-1:0]        r_s4_w;

    // stage 5: neighbor difference
    logic                       r_s5_valid;
    logic signed [COMP_W-1:0]   r_s5_a [NUM_COMP];
    logic signed [COMP_W:0]     r_s5_diff [NUM_COMP];
    logic [WEIGHT_W-1:0]        r_s5_w;
    logic signed [COMP_W-1:0]   n_s5_a [NUM_COMP];
    logic signed [COMP_W:0]     n_s5_diff [NUM_COMP];

    // stage 6: weighted step
    logic                       r_s6_valid;
    logic signed [COMP_W-1:0]   r_s6_a [NUM_COMP];
    logic [COMP_W-1:0]          r_s6_step [NUM_COMP];
    logic signed [WEIGHT_W:0]   n_s6_w;
    logic signed [49:0]         n_s6_prod [NUM_COMP];

    // stage 7: output register
    logic                       r_s7_valid;
    logic [COMP_W-1:0]          r_out [NUM_COMP];

    assign busy        = 1'b0;    // pipeline never stalls
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // configuration writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_min  <= MIN_POSITION_RESET;
            r_cfg_inv  <= INVERSE_SPACING_RESET;
            r_cfg_last <= LAST_INDEX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MIN_POSITION:    r_cfg_min  <= signed'(i_cfg_data);
                CFG_INVERSE_SPACING: r_cfg_inv  <= i_cfg_data;
                CFG_LAST_INDEX:      r_cfg_last <= i_cfg_data[INDEX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // valid bits travel with the items; only queries go past the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_s7_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid && (r_s3_kind == KIND_QUERY);
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid;
            r_s7_valid <= r_s6_valid;
        end
    end

    // stage 1: signed 33-bit offset, load components cut to the stored width
    always_comb begin
        n_s1_diff    = 33'(i_item.position) - 33'(r_cfg_min);
        n_s1_load[0] = i_item.load_e_x[EW-1:0];
        n_s1_load[1] = i_item.load_e_y[EW-1:0];
        n_s1_load[2] = i_item.load_e_z[EW-1:0];
        n_s1_load[3] = i_item.load_b_x[EW-1:0];
        n_s1_load[4] = i_item.load_b_y[EW-1:0];
        n_s1_load[5] = i_item.load_b_z[EW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind  <= i_item.kind;
            r_s1_index <= i_item.entry_index;
            r_s1_load  <= n_s1_load;
            r_s1_diff  <= n_s1_diff;
        end
    end

    // stage 2: offset times reciprocal spacing, Q32.32; at or below start maps to zero
    always_comb begin
        n_s2_below = r_s1_diff[POS_W] || (r_s1_diff == '0);
        n_s2_grid  = r_s1_diff[POS_W-1:0] * r_cfg_inv;
        if (n_s2_below) begin
            n_s2_grid = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_kind  <= r_s1_kind;
        r_s2_index <= r_s1_index;
        r_s2_load  <= r_s1_load;
        r_s2_ip    <= n_s2_grid[63:32];
        r_s2_w     <= n_s2_grid[31:16];
    end

    // stage 3: clamp last index, pick left entry, right entry only when weighted
    always_comb begin
        n_s3_last = 32'(r_cfg_last);
        if (n_s3_last == '0) begin
            n_s3_last = 32'd1;
        end else if (n_s3_last > LAST_MAX_32) begin
            n_s3_last = LAST_MAX_32;
        end
        n_s3_endpoint = (r_s2_ip >= n_s3_last);
        n_s3_left     = n_s3_endpoint ? n_s3_last[AW-1:0] : r_s2_ip[AW-1:0];
        n_s3_w        = n_s3_endpoint ? '0 : r_s2_w;
        // a zero weight reads the left entry twice, so the step is exactly zero
        n_s3_addr_b   = (n_s3_w == '0) ? n_s3_left : n_s3_left + AW'(1);
        n_s3_index    = 32'(r_s2_index);
        n_s3_addr_a   = (r_s2_kind == KIND_LOAD) ? n_s3_index[AW-1:0] : n_s3_left;
        for (int c = 0; c < NUM_COMP; c++) begin
            n_s3_wdata[c*EW +: EW] = r_s2_load[c];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_kind   <= r_s2_kind;
        r_s3_addr_a <= n_s3_addr_a;
        r_s3_addr_b <= n_s3_addr_b;
        r_s3_w      <= n_s3_w;
        r_s3_wr_en  <= (n_s3_index < DEPTH_32);   // loads past the grid are dropped
        r_s3_wdata  <= n_s3_wdata;
    end

    // stage 4: one write port for loads, two read ports for the neighbors
    always_ff @(posedge i_clk) begin
        if (r_s3_valid && (r_s3_kind == KIND_LOAD) && r_s3_wr_en) begin
            r_grid_mem[r_s3_addr_a] <= r_s3_wdata;
        end
        r_rd_a <= r_grid_mem[r_s3_addr_a];
        r_rd_b <= r_grid_mem[r_s3_addr_b];
        r_s4_w <= r_s3_w;
    end

    // stage 5: sign-extend and take b - a
    always_comb begin
        for (int c = 0; c < NUM_COMP; c++) begin
            n_s5_a[c]    = COMP_W'(signed'(r_rd_a[c*EW +: EW]));
            n_s5_diff[c] = (COMP_W+1)'(signed'(r_rd_b[c*EW +: EW])) -
                           (COMP_W+1)'(signed'(r_rd_a[c*EW +: EW]));
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_a    <= n_s5_a;
        r_s5_diff <= n_s5_diff;
        r_s5_w    <= r_s4_w;
    end

    // stage 6: (b - a) * w, floor by arithmetic shift of 16
    always_comb begin
        n_s6_w = signed'({1'b0, r_s5_w});
        for (int c = 0; c < NUM_COMP; c++) begin
            n_s6_prod[c] = r_s5_diff[c] * n_s6_w;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6_a <= r_s5_a;
        for (int c = 0; c < NUM_COMP; c++) begin
            r_s6_step[c] <= n_s6_prod[c][47:16];
        end
    end

    // stage 7: a + floor((b - a) * w / 65536), low 32 bits
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_COMP; c++) begin
            r_out[c] <= r_s6_a[c] + r_s6_step[c];
        end
    end

    assign o_strobe           = r_s7_valid;
    assign o_result.field_e_x = r_out[0];
    assign o_result.field_e_y = r_out[1];
    assign o_result.field_e_z = r_out[2];
    assign o_result.field_b_x = r_out[3];
    assign o_result.field_b_y = r_out[4];
    assign o_result.field_b_z = r_out[5];

endmodule

// File: rtl/core/gfli_checker.sv
// port-level timing checks for the grid field interpolator, bound to the top level
`timescale 1ns / 1ps

module gfli_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  gfli_pkg::t_in_item  i_item,
    input  logic                i_strobe
);
    import gfli_pkg::*;

    logic query_accept;
    logic load_accept;

    assign query_accept = i_start && !i_busy && (i_item.kind == KIND_QUERY);
    assign load_accept  = i_start && !i_busy && (i_item.kind == KIND_LOAD);

    // every query gives exactly one result at the fixed latency
    a_query_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        query_accept |-> ##LATENCY i_strobe)
        else $error("query item without result");

    // a load takes its slot but gives no result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_accept |-> ##LATENCY !i_strobe)
        else $error("load item produced a result");

    // no result without a query at the matching edge
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_strobe |-> $past(query_accept, LATENCY))
        else $error("result without a query item");

    // reset flushes the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_strobe)
        else $error("result right after reset");

endmodule

bind grid_field_linear_interp gfli_checker u_gfli_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (start),
    .i_busy   (busy),
    .i_item   (i_item),
    .i_strobe (o_strobe)
);
